[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define XES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xes check failed");

// next-cycle implication checked outside reset
`define XES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xes check failed");

`endif

[rtl/core/xes_pkg.sv]
// types, codes and constants of the xml element scanner
// no dependencies; imported by the scanner, its checker and the testbench
`default_nettype none

package xes_pkg;

  // nesting depth saturation limit and register width
  localparam int unsigned MAX_NEST = 255;
  localparam int unsigned NEST_W   = $clog2(MAX_NEST + 1);

  // byte codes
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // scanner phase
  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_ELEM = 2'd1,
    PH_CMT  = 2'd2
  } phase_e;

  // result word kind
  typedef enum logic [2:0] {
    K_BYTE     = 3'd0,
    K_DONE     = 3'd1,
    K_EXPECT   = 3'd2,
    K_EOF_IDLE = 3'd3,
    K_EOF_ELEM = 3'd4
  } kind_e;

  // results of one input word: held bytes to flush, then an optional tail word
  typedef struct packed {
    logic [1:0] flush_cnt;
    logic       tail_vld;
    kind_e      tail_kind;
    logic [7:0] tail_char;
  } res_t;

  // comment opening prefix "<!-", one byte per held position
  function automatic logic [7:0] pat_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CH_LT;
      2'd1:    b = CH_BANG;
      2'd2:    b = CH_DASH;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/core/xml_element_scanner.sv]
// xml element scanner top level: tokenizer state, result queue and output serializer
// depends on xes_pkg
`default_nettype none

// Streaming XML element scanner. One text byte (tuser low) or an end-of-file
// marker (tuser high) is taken per word. Whitespace between elements is skipped,
// element inner bytes come out in order with CR/LF dropped and comments
// ("<!--" ... "-->") removed, and each element ends with a done word. Error and
// end-of-file words are flagged in m_axis_tuser. An input word is taken every
// cycle while the output is not stalled and each word yields at most one result; a
// word that yields more (up to 4, when held "<!-" bytes are flushed) holds the output
// port, one result per cycle when not stalled. A two-entry result queue (output entry
// plus a pending entry) lets the next input word in while a result waits on the
// output. The scanner state is updated in the cycle the word is accepted.
module xml_element_scanner (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  wire logic       s_axis_tuser,   // [0] end_of_file
  // result stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_char
  output logic [2:0]      m_axis_tuser,   // [2:0] kind
  output logic            m_axis_tlast    // last result of the input word
);
  import xes_pkg::*;

  phase_e            phase_q, phase_d;
  logic [1:0]        prog_q, prog_d;
  logic [NEST_W-1:0] depth_q, depth_d;
  logic [1:0]        held_q, held_d;

  logic              cur_vld_q, cur_vld_d;
  res_t              cur_q, cur_d;
  logic [1:0]        pos_q, pos_d;
  logic              pend_vld_q, pend_vld_d;
  res_t              pend_q, pend_d;

  res_t              res;
  logic              res_vld;
  logic              in_acc, in_eof;
  logic [7:0]        c;
  logic              is_lt, is_gt, is_dash, is_crlf, is_ws;
  logic              app_hold;
  logic [1:0]        held_app;
  logic [NEST_W-1:0] depth_m1;
  logic              cmt_start;

  logic              in_flush, out_last, cur_done;

  // input decode
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_eof   = s_axis_tuser;
  assign c        = s_axis_tdata;
  assign is_lt    = (c == CH_LT);
  assign is_gt    = (c == CH_GT);
  assign is_dash  = (c == CH_DASH);
  assign is_crlf  = (c == CH_CR) || (c == CH_LF);
  assign is_ws    = is_crlf || (c == CH_TAB) || (c == CH_SPACE);

  // byte extends the held comment prefix, else held bytes flush
  assign app_hold  = (held_q != 2'd3) && (c == pat_byte(held_q));
  assign held_app  = app_hold ? (held_q + 2'd1) : (is_lt ? 2'd1 : 2'd0);
  assign depth_m1  = (depth_q != '0) ? (depth_q - NEST_W'(1)) : '0;
  assign cmt_start = is_dash && (held_q == 2'd3);

  // next scanner state
  always_comb begin
    phase_d = phase_q;
    prog_d  = prog_q;
    depth_d = depth_q;
    held_d  = held_q;
    if (in_acc) begin
      if (in_eof) begin
        phase_d = PH_SKIP;
        prog_d  = 2'd0;
        depth_d = NEST_W'(1);
        held_d  = 2'd0;
      end else begin
        unique case (phase_q)
          PH_ELEM: begin
            if (cmt_start) begin
              held_d  = 2'd0;
              phase_d = PH_CMT;
              prog_d  = 2'd0;
              if (depth_q > NEST_W'(1)) depth_d = depth_m1;
            end else if (is_lt) begin
              if (depth_q < NEST_W'(MAX_NEST)) depth_d = depth_q + NEST_W'(1);
              held_d = held_app;
            end else if (is_gt) begin
              if (depth_m1 == '0) begin
                phase_d = PH_SKIP;
                prog_d  = 2'd0;
                depth_d = NEST_W'(1);
                held_d  = 2'd0;
              end else begin
                depth_d = depth_m1;
                held_d  = held_app;
              end
            end else if (!is_crlf) begin
              held_d = held_app;
            end
          end
          PH_CMT: begin
            case (prog_q)
              2'd0:    prog_d = is_dash ? 2'd1 : 2'd0;
              2'd1:    prog_d = is_dash ? 2'd2 : 2'd0;
              default: begin
                if (is_gt) phase_d = PH_ELEM;
                prog_d = 2'd0;
              end
            endcase
          end
          default: begin
            phase_d = PH_SKIP;
            if (!is_ws && is_lt) begin
              phase_d = PH_ELEM;
              prog_d  = 2'd0;
              depth_d = NEST_W'(1);
              held_d  = 2'd0;
            end
          end
        endcase
      end
    end
  end

  // results of the accepted word
  always_comb begin
    res = '{flush_cnt: 2'd0, tail_vld: 1'b0, tail_kind: K_BYTE, tail_char: 8'h00};
    if (in_eof) begin
      if (phase_q == PH_ELEM || phase_q == PH_CMT) begin
        res.flush_cnt = held_q;
        res.tail_vld  = 1'b1;
        res.tail_kind = K_EOF_ELEM;
      end else begin
        res.tail_vld  = 1'b1;
        res.tail_kind = K_EOF_IDLE;
      end
    end else begin
      unique case (phase_q)
        PH_ELEM: begin
          if (cmt_start || is_crlf) begin
            res.tail_vld = 1'b0;
          end else if (is_gt && (depth_m1 == '0)) begin
            res.flush_cnt = held_q;
            res.tail_vld  = 1'b1;
            res.tail_kind = K_DONE;
          end else if (!app_hold) begin
            res.flush_cnt = held_q;
            if (!is_lt) begin
              res.tail_vld  = 1'b1;
              res.tail_kind = K_BYTE;
              res.tail_char = c;
            end
          end
        end
        PH_CMT: begin
          res.tail_vld = 1'b0;
        end
        default: begin
          if (!is_ws && !is_lt) begin
            res.tail_vld  = 1'b1;
            res.tail_kind = K_EXPECT;
          end
        end
      endcase
    end
  end

  assign res_vld = in_acc && ((res.flush_cnt != 2'd0) || res.tail_vld);

  // output serializer: held bytes first, then the tail word
  assign in_flush      = (pos_q < cur_q.flush_cnt);
  assign m_axis_tvalid = cur_vld_q;
  assign m_axis_tdata  = in_flush ? pat_byte(pos_q) : cur_q.tail_char;
  assign m_axis_tuser  = in_flush ? K_BYTE : cur_q.tail_kind;
  assign out_last      = in_flush ? ((pos_q == (cur_q.flush_cnt - 2'd1)) && !cur_q.tail_vld)
                                  : 1'b1;
  assign m_axis_tlast  = out_last;
  assign cur_done      = cur_vld_q && m_axis_tready && out_last;
  assign s_axis_tready = !pend_vld_q;

  // result queue update
  always_comb begin
    cur_vld_d  = cur_vld_q;
    cur_d      = cur_q;
    pos_d      = pos_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    if (!cur_vld_q || cur_done) begin
      pos_d = 2'd0;
      if (pend_vld_q) begin
        cur_d      = pend_q;
        cur_vld_d  = 1'b1;
        pend_vld_d = 1'b0;
      end else if (res_vld) begin
        cur_d     = res;
        cur_vld_d = 1'b1;
      end else begin
        cur_vld_d = 1'b0;
      end
    end else begin
      if (m_axis_tready) pos_d = pos_q + 2'd1;
      if (res_vld) begin
        pend_d     = res;
        pend_vld_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SKIP;
      prog_q     <= 2'd0;
      depth_q    <= NEST_W'(1);
      held_q     <= 2'd0;
      cur_vld_q  <= 1'b0;
      pos_q      <= 2'd0;
      pend_vld_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      prog_q     <= prog_d;
      depth_q    <= depth_d;
      held_q     <= held_d;
      cur_vld_q  <= cur_vld_d;
      pos_q      <= pos_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pend_q <= pend_d;
  end

endmodule

`default_nettype wire

[rtl/core/xes_checker.sv]
// port-level checker for the xml element scanner, bound to the top level
// depends on xes_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module xes_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);
  import xes_pkg::*;

  // a stalled result word holds its payload
  `XES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // non-byte words carry zero data
  `XES_ASSERT_IMPL(a_ctl_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != K_BYTE), m_axis_tdata == 8'h00)

  // done, error and end-of-file words always close their input word
  `XES_ASSERT_IMPL(a_ctl_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != K_BYTE), m_axis_tlast)

  // kind stays within the defined codes
  `XES_ASSERT_IMPL(a_kind_rng, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser <= K_EOF_ELEM)

endmodule

bind xml_element_scanner xes_checker u_xes_checker (.*);

`default_nettype wire

[tb/xes_tb_pkg.sv]
// scoreboard for the xml element scanner testbench: token predictor and result check
// depends on xes_pkg for the byte codes, phase and kind enums
`timescale 1ns / 100ps

package xes_tb_pkg;
  import xes_pkg::*;

  // one result word as it leaves the scanner
  typedef struct packed {
    logic [7:0] ch;
    kind_e      kind;
    logic       last;
  } token_t;

  class token_scoreboard;
    // scanner state as the predictor tracks it
    phase_e      scan_phase;
    logic [1:0]  close_run;
    int unsigned nest_depth;
    logic [7:0]  held_bytes [3];
    int unsigned held_cnt;

    // tokens of the current input word, and tokens still owed by the block
    token_t      step_tokens [$];
    token_t      owed_tokens [$];

    int unsigned words_in;
    int unsigned tokens_ok;
    int unsigned mismatches;
    int unsigned elements_closed;
    int unsigned comments_opened;
    int unsigned eof_words;
    int unsigned syntax_errors;

    function new();
      words_in        = 0;
      tokens_ok       = 0;
      mismatches      = 0;
      elements_closed = 0;
      comments_opened = 0;
      eof_words       = 0;
      syntax_errors   = 0;
      go_idle();
    endfunction

    function void go_idle();
      scan_phase = PH_SKIP;
      close_run  = 2'd0;
      nest_depth = 1;
      held_cnt   = 0;
      foreach (held_bytes[i]) held_bytes[i] = 8'h00;
    endfunction

    // at most four tokens per input word
    function void emit(logic [7:0] ch, kind_e kind);
      token_t t;
      if (step_tokens.size() >= 4) return;
      t.ch   = ch;
      t.kind = kind;
      t.last = 1'b0;
      step_tokens.insert(step_tokens.size(), t);
    endfunction

    function void flush_held();
      for (int i = 0; i < held_cnt && i < 3; i++) emit(held_bytes[i], K_BYTE);
      held_cnt = 0;
    endfunction

    // element byte: hold it while it still extends the "<!-" prefix
    function void add_byte(logic [7:0] c);
      if (held_cnt < 3 && c == pat_char(held_cnt)) begin
        held_bytes[held_cnt] = c;
        held_cnt++;
        return;
      end
      flush_held();
      if (c == CH_LT) begin
        held_bytes[0] = c;
        held_cnt = 1;
      end else begin
        emit(c, K_BYTE);
      end
    endfunction

    function logic [7:0] pat_char(int unsigned idx);
      case (idx)
        0:       return CH_LT;
        1:       return CH_BANG;
        default: return CH_DASH;
      endcase
    endfunction

    // accepted input word: advance the scanner and queue its tokens
    function void take_word(logic [7:0] c, logic eof);
      step_tokens.delete();
      words_in++;
      if (eof) begin
        eof_words++;
        if (scan_phase == PH_SKIP) begin
          emit(8'h00, K_EOF_IDLE);
        end else begin
          flush_held();
          emit(8'h00, K_EOF_ELEM);
        end
        go_idle();
      end else if (scan_phase == PH_SKIP) begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
          // whitespace between elements
        end else if (c == CH_LT) begin
          go_idle();
          scan_phase = PH_ELEM;
        end else begin
          syntax_errors++;
          emit(8'h00, K_EXPECT);
        end
      end else if (scan_phase == PH_CMT) begin
        // closing run matched in non-overlapping groups of three
        case (close_run)
          2'd0:    close_run = (c == CH_DASH) ? 2'd1 : 2'd0;
          2'd1:    close_run = (c == CH_DASH) ? 2'd2 : 2'd0;
          default: begin
            if (c == CH_GT) scan_phase = PH_ELEM;
            close_run = 2'd0;
          end
        endcase
      end else begin
        if (c == CH_DASH && held_cnt == 3) begin
          held_cnt   = 0;
          scan_phase = PH_CMT;
          close_run  = 2'd0;
          if (nest_depth > 1) nest_depth--;
          comments_opened++;
        end else if (c == CH_LT) begin
          if (nest_depth < MAX_NEST) nest_depth++;
          add_byte(c);
        end else if (c == CH_GT) begin
          if (nest_depth > 0) nest_depth--;
          if (nest_depth == 0) begin
            flush_held();
            emit(8'h00, K_DONE);
            go_idle();
            elements_closed++;
          end else begin
            add_byte(c);
          end
        end else if (c == CH_CR || c == CH_LF) begin
          // line breaks dropped inside elements
        end else begin
          add_byte(c);
        end
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) owed_tokens.insert(owed_tokens.size(), step_tokens[i]);
    endfunction

    // accepted result word against the oldest owed token
    function void check_word(logic [7:0] ch, logic [2:0] kind, logic last);
      token_t want;
      if (owed_tokens.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: char %h kind %0d last %b", ch, kind, last);
        mismatches++;
        return;
      end
      want = owed_tokens.pop_front();
      if (want.ch !== ch || 3'(want.kind) !== kind || want.last !== last) begin
        if (mismatches < 10)
          $display({"result %0d mismatch: expected char %h kind %0d last %b,",
                    " got char %h kind %0d last %b"},
                   tokens_ok + mismatches, want.ch, want.kind, want.last, ch, kind, last);
        mismatches++;
      end else begin
        tokens_ok++;
      end
    endfunction

    function int unsigned owed();
      return owed_tokens.size();
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
// top of the xml element scanner testbench: clock, reset, stream drivers and monitors
// depends on xes_pkg, xes_tb_pkg and the xml_element_scanner rtl
`timescale 1ns / 100ps

module tb_top;
  import xes_pkg::*;
  import xes_tb_pkg::*;

  localparam int unsigned TOTAL_WORDS  = 450;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
  } stim_word_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tuser  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  int unsigned     src_idle_pct = 29;
  int unsigned     snk_idle_pct = 51;
  bit              stall_req    = 1'b0;
  int unsigned     cycle_cnt    = 0;
  stim_word_t      stim_q [$];
  token_scoreboard sb;

  xml_element_scanner DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // word monitors on both streams
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.take_word(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        hold_left = HOLD_CYCLES;
        stall_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // stimulus building blocks
  function automatic void push_byte(logic [7:0] c);
    stim_word_t w;
    w.ch  = c;
    w.eof = 1'b0;
    stim_q.insert(stim_q.size(), w);
  endfunction

  function automatic void push_eof();
    stim_word_t w;
    w.ch  = 8'($urandom_range(255));
    w.eof = 1'b1;
    stim_q.insert(stim_q.size(), w);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_text();
    case ($urandom_range(6))
      0:       return CH_DASH;
      1:       return CH_BANG;
      2:       return CH_SPACE;
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  function automatic logic [7:0] pick_comment_byte();
    case ($urandom_range(5))
      0:       return CH_DASH;
      1:       return CH_GT;
      2:       return CH_LT;
      3:       return CH_LF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // comment with random body, closed by a "-->" run
  function automatic void push_comment();
    push_text("<!--");
    repeat ($urandom_range(6)) push_byte(pick_comment_byte());
    push_text("-->");
  endfunction

  // mostly balanced element with nested elements, comments and near-miss prefixes
  function automatic void push_element(int lvl);
    int sel;
    push_byte(CH_LT);
    repeat ($urandom_range(1, 10)) begin
      sel = $urandom_range(99);
      if (sel < 50) push_byte(pick_text());
      else if (sel < 62) push_comment();
      else if (sel < 72 && lvl < 3) push_element(lvl + 1);
      else if (sel < 80) push_byte($urandom_range(1) ? CH_CR : CH_LF);
      else if (sel < 90) begin
        // "<!>" or "<!->": held prefix that turns out not to open a comment
        push_byte(CH_LT);
        push_byte(CH_BANG);
        if ($urandom_range(1)) push_byte(CH_DASH);
        push_byte(CH_GT);
      end else push_byte(8'($urandom_range(255)));
    end
    push_byte(CH_GT);
  endfunction

  function automatic void build_stimulus();
    int sel;
    // directed: whitespace, bad first bytes, idle end of file
    push_text(" \t\r\n");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_eof();
    // element with a comment inside
    push_text("<a<!--x-->b>");
    // element opener is not part of a comment start
    push_text("<!-->");
    // end of file with "<!-" held: three flushed bytes and the eof word
    push_text("<<!-");
    push_eof();
    // deep nesting: every inner '<' needs its own closer
    push_byte(CH_LT);
    repeat (12) push_byte(CH_LT);
    push_byte(8'h71);
    repeat (13) push_byte(CH_GT);
    push_byte(CH_LF);
    // random traffic, mostly well-formed elements
    while (stim_q.size() < TOTAL_WORDS) begin
      sel = $urandom_range(99);
      repeat ($urandom_range(2)) push_byte(pick_space());
      if (sel < 72) push_element(0);
      else if (sel < 82) push_byte(8'($urandom_range(255)));
      else if (sel < 88) push_eof();
      else begin
        // element cut short by end of file, sometimes inside a comment
        push_byte(CH_LT);
        repeat ($urandom_range(1, 4)) push_byte(pick_text());
        if ($urandom_range(1)) begin
          push_text("<!-");
          if ($urandom_range(1)) push_byte(CH_DASH);
        end
        push_eof();
      end
    end
  endfunction

  // offer one word and wait for it to be taken
  task automatic send_word(input stim_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w.ch;
    s_axis_tuser  <= w.eof;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // main sequence
  initial begin
    int unsigned total;
    sb = new();
    build_stimulus();
    total = stim_q.size();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int unsigned i = 0; i < total; i++) begin
      if (i == total / 3) begin
        src_idle_pct = 51;
        snk_idle_pct = 29;
      end else if (i == 2 * total / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_req    = 1'b1;
      end
      send_word(stim_q[i]);
    end
    s_axis_tvalid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("scanned %0d input words into %0d matching result words, %0d mismatched",
             sb.words_in, sb.tokens_ok, sb.mismatches);
    $display("elements closed %0d, comments %0d, end-of-file words %0d, syntax errors %0d",
             sb.elements_closed, sb.comments_opened, sb.eof_words, sb.syntax_errors);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
